### rtl/rbx_pkg.sv
// Shared constants, types and helpers for the ray box exit point block.
// No dependencies; every other file imports this package.
package rbx_pkg;

	localparam int POS_W     = 32;
	localparam int LOW_W     = 32;
	localparam int DIR_W     = 18;
	localparam int EXT_PW    = 16;
	localparam int DIV_STEPS = 4;

	typedef logic [2:0] face_t;

	localparam face_t FACE_NX   = 3'd0;
	localparam face_t FACE_PX   = 3'd1;
	localparam face_t FACE_NY   = 3'd2;
	localparam face_t FACE_PY   = 3'd3;
	localparam face_t FACE_NZ   = 3'd4;
	localparam face_t FACE_PZ   = 3'd5;
	localparam face_t FACE_NONE = 3'd6;

	function automatic int other_axis(input int a, input int j);
		if (a == 0) begin
			return j + 1;
		end
		if (a == 1) begin
			return (j == 0) ? 0 : 2;
		end
		return j;
	endfunction

endpackage

### rtl/rbx_mul.sv
// Front stage of one offset lane: magnitudes, sign and the wide product.
// Depends on rbx_pkg.
module rbx_mul import rbx_pkg::*; #(
	parameter int DW = 34,
	localparam int PW = DW - 1 + DIR_W
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [DW-1:0]    pdist,
	input  logic signed [DIR_W-1:0] num,
	input  logic signed [DIR_W-1:0] den,
	output logic [PW-1:0]           prod_s1,
	output logic [DIR_W-1:0]        den_mag_s1,
	output logic                    neg_s1
);

	logic [DW-1:0]    dist_abs;
	logic [DW-2:0]    dist_mag;
	logic [DIR_W-1:0] num_mag;
	logic [DIR_W-1:0] den_mag;
	logic [PW-1:0]    prod;

	always_comb begin
		dist_abs = pdist[DW-1] ? DW'(-pdist) : DW'(pdist);
		dist_mag = dist_abs[DW-2:0];
		num_mag  = num[DIR_W-1] ? DIR_W'(-num) : DIR_W'(num);
		den_mag  = den[DIR_W-1] ? DIR_W'(-den) : DIR_W'(den);
		prod     = PW'(dist_mag) * PW'(num_mag);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1    <= prod;
			den_mag_s1 <= den_mag;
			neg_s1     <= pdist[DW-1] ^ num[DIR_W-1] ^ den[DIR_W-1];
		end
	end

endmodule

### rtl/rbx_div.sv
// Pipelined restoring divider with saturation, a few quotient bits per stage.
// Depends on rbx_pkg.
module rbx_div import rbx_pkg::*; #(
	parameter int PW = 51,
	parameter int QB = 34
) (
	input  logic             clk,
	input  logic             en,
	input  logic [PW-1:0]    prod,
	input  logic [DIR_W-1:0] den_mag,
	input  logic             neg,
	output logic [QB-1:0]    quo,
	output logic             neg_o
);

	localparam int NST = (QB + DIV_STEPS - 1) / DIV_STEPS;
	localparam int NB  = NST * DIV_STEPS;

	logic [DIR_W-1:0] rem_s [0:NST];
	logic [NB-1:0]    dvd_s [0:NST];
	logic [NB-1:0]    quo_s [0:NST];
	logic [DIR_W-1:0] c_s   [0:NST];
	logic             neg_s [0:NST];
	logic             sat_s [0:NST];

	assign rem_s[0] = DIR_W'(prod >> NB);
	assign dvd_s[0] = prod[NB-1:0];
	assign quo_s[0] = '0;
	assign c_s[0]   = den_mag;
	assign neg_s[0] = neg;
	assign sat_s[0] = (prod >> QB) >= PW'(den_mag);

	for (genvar g = 0; g < NST; g++) begin : g_stage
		logic [DIR_W:0]   r;
		logic [NB-1:0]    d;
		logic [NB-1:0]    q;

		always_comb begin
			r = {1'b0, rem_s[g]};
			d = dvd_s[g];
			q = quo_s[g];
			for (int i = 0; i < DIV_STEPS; i++) begin
				r = {r[DIR_W-1:0], d[NB-1]};
				d = d << 1;
				if (r >= {1'b0, c_s[g]}) begin
					r = r - {1'b0, c_s[g]};
					q = {q[NB-2:0], 1'b1};
				end else begin
					q = {q[NB-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= r[DIR_W-1:0];
				dvd_s[g+1] <= d;
				quo_s[g+1] <= q;
				c_s[g+1]   <= c_s[g];
				neg_s[g+1] <= neg_s[g];
				sat_s[g+1] <= sat_s[g];
			end
		end
	end

	assign quo   = sat_s[NST] ? '1 : quo_s[NST][QB-1:0];
	assign neg_o = neg_s[NST];

endmodule

### rtl/rbx_dly.sv
// Enabled delay line that carries side data alongside the divider stages.
// Depends on rbx_pkg only by convention of the project.
module rbx_dly import rbx_pkg::*; #(
	parameter int W = 8,
	parameter int N = 2
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] dly_s [0:N-1];

	always_ff @(posedge clk) begin
		if (en) begin
			dly_s[0] <= d;
			for (int i = 1; i < N; i++) begin
				dly_s[i] <= dly_s[i-1];
			end
		end
	end

	assign q = dly_s[N-1];

endmodule

### rtl/ray_box_exit_point.sv
// Ray against axis-aligned box: finds the exit face, exit position and voxel.
// Depends on rbx_pkg, rbx_mul, rbx_div and rbx_dly.
//
// Usage: one ray word enters on the input channel (in_valid, in_stall) and
// one result word leaves on the output channel (out_valid, out_stall) for
// every ray, in order. A new ray can be accepted in every cycle in which
// in_stall is low. The signed plane distance is one bit wider than the
// larger of 32 and (extent plus fraction bits + 1); with the default
// parameters that is 34 bits. The six offset divisions run in parallel
// restoring dividers that retire four quotient bits per stage, and these
// set the depth.
// Throughput is one ray per cycle unless out_stall holds a waiting result;
// then the whole pipeline holds and in_stall is raised; nothing is lost.
// Reset clears all valid bits; no result appears until rays are accepted.
module ray_box_exit_point import rbx_pkg::*; #(
	parameter int FRAC_BITS   = 16,
	parameter int EXTENT_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [LOW_W-1:0] box_low_x,
	input  logic signed [LOW_W-1:0] box_low_y,
	input  logic signed [LOW_W-1:0] box_low_z,
	input  logic [EXT_PW-1:0]       extent_x,
	input  logic [EXT_PW-1:0]       extent_y,
	input  logic [EXT_PW-1:0]       extent_z,
	input  logic signed [POS_W-1:0] start_x,
	input  logic signed [POS_W-1:0] start_y,
	input  logic signed [POS_W-1:0] start_z,
	input  logic signed [DIR_W-1:0] dir_x,
	input  logic signed [DIR_W-1:0] dir_y,
	input  logic signed [DIR_W-1:0] dir_z,
	output logic                    out_valid,
	input  logic                    out_stall,
	output face_t                   exit_face,
	output logic signed [LOW_W-1:0] voxel_x,
	output logic signed [LOW_W-1:0] voxel_y,
	output logic signed [LOW_W-1:0] voxel_z,
	output logic signed [POS_W-1:0] moved_x,
	output logic signed [POS_W-1:0] moved_y,
	output logic signed [POS_W-1:0] moved_z
);

	localparam int EU  = (EXTENT_BITS < EXT_PW) ? EXTENT_BITS : EXT_PW;
	localparam int FW  = EU + FRAC_BITS;
	localparam int DW  = ((FW + 1 > POS_W) ? FW + 1 : POS_W) + 1;
	localparam int PW  = DW - 1 + DIR_W;
	localparam int QB  = DW;
	localparam int RW  = QB + 1;
	localparam int NST = (QB + DIV_STEPS - 1) / DIV_STEPS;
	localparam int XW  = RW + 1 + FRAC_BITS + POS_W;
	localparam int SW1 = LOW_W + EU + POS_W + 2;
	localparam int SW  = 3 * SW1;

	function automatic logic signed [DW-1:0] far_of(input logic signed [POS_W-1:0] p,
		input logic [EU-1:0] e);
		logic signed [DW-1:0] ps;
		logic signed [DW-1:0] es;
		ps = DW'(p);
		es = $signed({{(DW - FW){1'b0}}, e, {FRAC_BITS{1'b0}}});
		return ps - es;
	endfunction

	logic                    en;
	logic signed [LOW_W-1:0] low_in [3];
	logic [EU-1:0]           ext_in [3];
	logic signed [POS_W-1:0] pos_in [3];
	logic signed [DIR_W-1:0] dir_in [3];
	logic signed [DW-1:0]    dist_in [3];
	logic [SW-1:0]           side_in;
	logic [SW-1:0]           side_d;
	logic                    vld_s [0:NST];

	logic [QB-1:0]           quo_d [6];
	logic                    neg_d [6];
	logic signed [LOW_W-1:0] low_d [3];
	logic [EU-1:0]           ext_d [3];
	logic signed [POS_W-1:0] pos_d [3];
	logic [2:0]              dneg_d;
	logic [2:0]              dpos_d;
	logic signed [RW-1:0]    res_d [6];
	logic [5:0]              lane_ok;

	logic signed [RW-1:0]    res_sc [6];
	logic [2:0]              axok_sc;
	logic signed [LOW_W-1:0] low_sc [3];
	logic [EU-1:0]           ext_sc [3];
	logic signed [POS_W-1:0] pos_sc [3];
	logic [2:0]              dpos_sc;
	logic                    vld_sc;

	face_t                   face_c;
	logic signed [LOW_W-1:0] vox_c [3];
	logic signed [POS_W-1:0] mv_c [3];

	face_t                   face_so;
	logic signed [LOW_W-1:0] vox_so [3];
	logic signed [POS_W-1:0] mv_so [3];
	logic                    vld_so;

	assign en       = !(vld_so && out_stall);
	assign in_stall = !en;

	assign low_in[0] = box_low_x;
	assign low_in[1] = box_low_y;
	assign low_in[2] = box_low_z;
	assign ext_in[0] = extent_x[EU-1:0];
	assign ext_in[1] = extent_y[EU-1:0];
	assign ext_in[2] = extent_z[EU-1:0];
	assign pos_in[0] = start_x;
	assign pos_in[1] = start_y;
	assign pos_in[2] = start_z;
	assign dir_in[0] = dir_x;
	assign dir_in[1] = dir_y;
	assign dir_in[2] = dir_z;

	for (genvar k = 0; k < 3; k++) begin : g_axis
		assign dist_in[k] = dir_in[k][DIR_W-1] ? DW'(pos_in[k]) : far_of(pos_in[k], ext_in[k]);
		assign side_in[k*SW1 +: SW1] = {low_in[k], ext_in[k], pos_in[k],
			dir_in[k][DIR_W-1], (!dir_in[k][DIR_W-1] && (dir_in[k] != '0))};
		assign {low_d[k], ext_d[k], pos_d[k], dneg_d[k], dpos_d[k]} = side_d[k*SW1 +: SW1];
	end

	for (genvar a = 0; a < 3; a++) begin : g_face
		for (genvar j = 0; j < 2; j++) begin : g_lane
			localparam int B = other_axis(a, j);
			logic [PW-1:0]    prod_s1;
			logic [DIR_W-1:0] den_mag_s1;
			logic             neg_s1;
			logic signed [RW-1:0] mag;

			rbx_mul #(.DW(DW)) u_mul (
				.clk        (clk),
				.en         (en),
				.pdist      (dist_in[a]),
				.num        (dir_in[B]),
				.den        (dir_in[a]),
				.prod_s1    (prod_s1),
				.den_mag_s1 (den_mag_s1),
				.neg_s1     (neg_s1)
			);

			rbx_div #(.PW(PW), .QB(QB)) u_div (
				.clk     (clk),
				.en      (en),
				.prod    (prod_s1),
				.den_mag (den_mag_s1),
				.neg     (neg_s1),
				.quo     (quo_d[2*a+j]),
				.neg_o   (neg_d[2*a+j])
			);

			assign mag = $signed({1'b0, quo_d[2*a+j]});
			assign res_d[2*a+j] = neg_d[2*a+j] ? -mag : mag;
			assign lane_ok[2*a+j] = (RW'(pos_d[B]) >= res_d[2*a+j]) &&
				(res_d[2*a+j] >= RW'(far_of(pos_d[B], ext_d[B])));
		end
	end

	rbx_dly #(.W(SW), .N(NST + 1)) u_side (
		.clk (clk),
		.en  (en),
		.d   (side_in),
		.q   (side_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NST; i++) begin
				vld_s[i] <= 1'b0;
			end
			vld_sc <= 1'b0;
			vld_so <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i <= NST; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
			vld_sc <= vld_s[NST];
			vld_so <= vld_sc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 6; l++) begin
				res_sc[l] <= res_d[l];
			end
			for (int k = 0; k < 3; k++) begin
				axok_sc[k] <= (dneg_d[k] || dpos_d[k]) && lane_ok[2*k] && lane_ok[2*k+1];
				low_sc[k]  <= low_d[k];
				ext_sc[k]  <= ext_d[k];
				pos_sc[k]  <= pos_d[k];
			end
			dpos_sc <= dpos_d;
		end
	end

	always_comb begin
		logic [1:0]           sel;
		logic                 hit;
		logic                 hi;
		logic signed [XW-1:0] diff;
		logic [XW-1:0]        em;
		sel  = '0;
		hit  = 1'b0;
		hi   = 1'b0;
		diff = '0;
		em   = '0;
		for (int a = 2; a >= 0; a--) begin
			if (axok_sc[a]) begin
				sel = 2'(a);
				hit = 1'b1;
				hi  = dpos_sc[a];
			end
		end
		face_c = hit ? face_t'({sel, hi}) : FACE_NONE;
		for (int k = 0; k < 3; k++) begin
			vox_c[k] = '0;
			mv_c[k]  = '0;
			for (int a = 0; a < 3; a++) begin
				if (hit && (sel == 2'(a))) begin
					if (k == a) begin
						em       = XW'(ext_sc[k]) << FRAC_BITS;
						mv_c[k]  = hi ? POS_W'(em) : '0;
						vox_c[k] = low_sc[k] + (hi ? LOW_W'(ext_sc[k]) : '0);
					end else begin
						diff = XW'(pos_sc[k]) -
							XW'(res_sc[2*a + ((other_axis(a, 0) == k) ? 0 : 1)]);
						mv_c[k]  = POS_W'(diff);
						vox_c[k] = low_sc[k] + LOW_W'(diff >>> FRAC_BITS);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			face_so <= face_c;
			for (int k = 0; k < 3; k++) begin
				vox_so[k] <= vox_c[k];
				mv_so[k]  <= mv_c[k];
			end
		end
	end

	assign out_valid = vld_so;
	assign exit_face = face_so;
	assign voxel_x   = vox_so[0];
	assign voxel_y   = vox_so[1];
	assign voxel_z   = vox_so[2];
	assign moved_x   = mv_so[0];
	assign moved_y   = mv_so[1];
	assign moved_z   = mv_so[2];

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (exit_face == FACE_NONE) |-> (voxel_x == 0) && (voxel_y == 0) &&
		(voxel_z == 0) && (moved_x == 0) && (moved_y == 0) && (moved_z == 0))
		else $error("miss result carries nonzero fields");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	a_low_face: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (exit_face != FACE_NX || moved_x == 0) &&
		(exit_face != FACE_NY || moved_y == 0) && (exit_face != FACE_NZ || moved_z == 0))
		else $error("low face exit with nonzero position on its axis");

endmodule
